### rtl/lsbi_pkg.sv
`timescale 1ns / 1ps

package lsbi_pkg;

    localparam int DATA_W     = 8;
    localparam int BS_W       = 7;
    localparam int SEED_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd2;

    localparam logic [SEED_W-1:0] LFSR_TAPS  = 32'hb4bc_d35c;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'h0000_0001;
    localparam logic [BS_W-1:0]   BS_RESET   = 7'd64;

    // controller to datapath commands
    typedef struct packed {
        logic init_wr;
        logic idx_clr;
        logic idx_inc;
        logic idx_dec;
        logic idx_to_last;
        logic lfsr_step;
        logic div_step;
        logic mem_rd;
        logic wr_i;
        logic wr_j;
        logic inv_wr;
        logic buf_rd;
        logic load_en;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic cfg_hit;
        logic idx_last;
        logic idx_one;
        logic n_is_one;
        logic div_last;
        logic load_done;
        logic out_free;
    } stat_t;

endpackage

### rtl/lsbi_stream_if.sv
`timescale 1ns / 1ps

interface lsbi_in_if;
    logic                        valid;
    logic                        ready;
    logic [lsbi_pkg::DATA_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface lsbi_out_if;
    logic                        valid;
    logic                        ready;
    logic [lsbi_pkg::DATA_W-1:0] out_byte;
    logic                        last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

### rtl/lsbi_ctrl.sv
`timescale 1ns / 1ps

module lsbi_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  lsbi_pkg::stat_t stat,
    output lsbi_pkg::cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_INIT  = 12'b0000_0000_0001,
        S_LFSR  = 12'b0000_0000_0010,
        S_DIV   = 12'b0000_0000_0100,
        S_RDSW  = 12'b0000_0000_1000,
        S_WRI   = 12'b0000_0001_0000,
        S_WRJ   = 12'b0000_0010_0000,
        S_INVRD = 12'b0000_0100_0000,
        S_INVWR = 12'b0000_1000_0000,
        S_LOAD  = 12'b0001_0000_0000,
        S_TAB   = 12'b0010_0000_0000,
        S_BUF   = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (stat.idx_last)
                begin
                    if (stat.n_is_one)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_INVRD;
                    end
                    else
                    begin
                        cmd.idx_to_last = 1'b1;
                        state_next      = S_LFSR;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_LFSR:
            begin
                cmd.lfsr_step = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_RDSW;
                end
            end
            S_RDSW:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_WRI;
            end
            S_WRI:
            begin
                cmd.wr_i   = 1'b1;
                state_next = S_WRJ;
            end
            S_WRJ:
            begin
                cmd.wr_j = 1'b1;
                if (stat.idx_one)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_INVRD;
                end
                else
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_LFSR;
                end
            end
            S_INVRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_INVWR;
            end
            S_INVWR:
            begin
                cmd.inv_wr = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_INVRD;
                end
            end
            S_LOAD:
            begin
                cmd.load_en = 1'b1;
                if (stat.load_done)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_TAB;
                end
            end
            S_TAB:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_BUF;
            end
            S_BUF:
            begin
                cmd.buf_rd = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.idx_last)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_TAB;
                    end
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // state register, restart the build on a write to block size, seed or direction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else if (stat.cfg_hit)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/lsbi_datapath.sv
`timescale 1ns / 1ps

module lsbi_datapath
#(
    parameter int MAX_BLOCK = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsbi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsbi_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    input  logic [lsbi_pkg::DATA_W-1:0]         in_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [lsbi_pkg::DATA_W-1:0]         out_data,
    output logic                                out_last,
    input  lsbi_pkg::cmd_t                      cmd,
    output lsbi_pkg::stat_t                     stat
);

    localparam int AW = $clog2(MAX_BLOCK);
    localparam int CW = $clog2(MAX_BLOCK + 1);

    logic [lsbi_pkg::BS_W-1:0]   bs_reg;
    logic [lsbi_pkg::SEED_W-1:0] seed_reg;
    logic                        dir_reg;
    logic                        cfg_hit;

    logic [lsbi_pkg::BS_W-1:0]   n_full;
    logic [AW-1:0]               nm1;

    logic [AW-1:0]               idx_reg;
    logic [AW-1:0]               fill_reg;
    logic [lsbi_pkg::SEED_W-1:0] lfsr_reg;
    logic [lsbi_pkg::SEED_W-1:0] lfsr_next;
    logic [lsbi_pkg::SEED_W-1:0] q_reg;
    logic [CW-1:0]               rem_reg;
    logic [CW-1:0]               rem_next;
    logic [CW:0]                 trial;
    logic [CW-1:0]               divisor;
    logic [lsbi_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [AW-1:0]               j_addr;

    logic [AW-1:0]               fwd_mem [MAX_BLOCK];
    logic [AW-1:0]               inv_mem [MAX_BLOCK];
    logic [lsbi_pkg::DATA_W-1:0] buf_mem [MAX_BLOCK];
    logic [AW-1:0]               fwd_rd_a_reg;
    logic [AW-1:0]               fwd_rd_b_reg;
    logic [AW-1:0]               inv_rd_reg;
    logic [lsbi_pkg::DATA_W-1:0] buf_rd_reg;
    logic [AW-1:0]               src_addr;

    logic                        fwd_we;
    logic [AW-1:0]               fwd_waddr;
    logic [AW-1:0]               fwd_wdata;
    logic                        in_acc;

    logic                        out_valid_reg;
    logic [lsbi_pkg::DATA_W-1:0] out_data_reg;
    logic                        out_last_reg;

    assign cfg_hit = cfg_we && ((cfg_index == lsbi_pkg::REG_BLOCK_SIZE) ||
                                (cfg_index == lsbi_pkg::REG_SEED) ||
                                (cfg_index == lsbi_pkg::REG_DIRECTION));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg   <= lsbi_pkg::BS_RESET;
            seed_reg <= lsbi_pkg::SEED_RESET;
            dir_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsbi_pkg::REG_BLOCK_SIZE: bs_reg   <= cfg_data[lsbi_pkg::BS_W-1:0];
                lsbi_pkg::REG_SEED:       seed_reg <= cfg_data;
                lsbi_pkg::REG_DIRECTION:  dir_reg  <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // effective block size, clamped to one and to the maximum
    always_comb
    begin
        if (bs_reg == '0)
        begin
            n_full = lsbi_pkg::BS_W'(1);
        end
        else if (bs_reg > lsbi_pkg::BS_W'(MAX_BLOCK))
        begin
            n_full = lsbi_pkg::BS_W'(MAX_BLOCK);
        end
        else
        begin
            n_full = bs_reg;
        end
    end

    assign nm1 = AW'(n_full - lsbi_pkg::BS_W'(1));

    // galois lfsr step
    assign lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? lsbi_pkg::LFSR_TAPS : '0);

    // one remainder bit per cycle, divisor is i+1
    assign divisor  = CW'(idx_reg) + CW'(1);
    assign trial    = {rem_reg, q_reg[lsbi_pkg::SEED_W-1]};
    assign rem_next = (trial >= {1'b0, divisor}) ? CW'(trial - {1'b0, divisor})
                                                 : trial[CW-1:0];
    assign j_addr   = rem_reg[AW-1:0];

    assign in_acc = cmd.load_en && in_valid;

    // index, fill, lfsr and divider registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            fill_reg    <= '0;
            lfsr_reg    <= lsbi_pkg::SEED_RESET;
            div_cnt_reg <= '0;
        end
        else if (cfg_hit)
        begin
            idx_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_to_last)
            begin
                idx_reg <= nm1;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - AW'(1);
            end

            if (cmd.init_wr)
            begin
                lfsr_reg <= seed_reg;
            end
            else if (cmd.lfsr_step)
            begin
                lfsr_reg <= lfsr_next;
            end

            if (cmd.lfsr_step)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + lsbi_pkg::DIV_CNT_W'(1);
            end

            if (in_acc)
            begin
                fill_reg <= (fill_reg == nm1) ? '0 : fill_reg + AW'(1);
            end
        end
    end

    // divider payload
    always_ff @(posedge clk)
    begin
        if (cmd.lfsr_step)
        begin
            q_reg   <= lfsr_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= q_reg << 1;
            rem_reg <= rem_next;
        end
    end

    // forward table write port
    always_comb
    begin
        fwd_we    = cmd.init_wr || cmd.wr_i || cmd.wr_j;
        fwd_waddr = idx_reg;
        fwd_wdata = idx_reg;
        if (cmd.wr_i)
        begin
            fwd_wdata = fwd_rd_b_reg;
        end
        else if (cmd.wr_j)
        begin
            fwd_waddr = j_addr;
            fwd_wdata = fwd_rd_a_reg;
        end
    end

    assign src_addr = dir_reg ? inv_rd_reg : fwd_rd_a_reg;

    // table and buffer memories
    always_ff @(posedge clk)
    begin
        if (fwd_we)
        begin
            fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        if (cmd.inv_wr)
        begin
            inv_mem[fwd_rd_a_reg] <= idx_reg;
        end
        if (in_acc)
        begin
            buf_mem[fill_reg] <= in_data;
        end
        if (cmd.mem_rd)
        begin
            fwd_rd_a_reg <= fwd_mem[idx_reg];
            fwd_rd_b_reg <= fwd_mem[j_addr];
            inv_rd_reg   <= inv_mem[idx_reg];
        end
        if (cmd.buf_rd)
        begin
            buf_rd_reg <= buf_mem[src_addr];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= buf_rd_reg;
            out_last_reg <= (idx_reg == nm1);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    // status back to the controller
    always_comb
    begin
        stat.cfg_hit   = cfg_hit;
        stat.idx_last  = (idx_reg == nm1);
        stat.idx_one   = (idx_reg == AW'(1));
        stat.n_is_one  = (nm1 == '0);
        stat.div_last  = (div_cnt_reg == lsbi_pkg::DIV_CNT_W'(lsbi_pkg::DIV_STEPS - 1));
        stat.load_done = in_acc && (fill_reg == nm1);
        stat.out_free  = !out_valid_reg || out_ready;
    end

endmodule

### rtl/lfsr_seeded_block_interleaver.sv
`timescale 1ns / 1ps
// input: one byte per cycle while a block loads; the block of n bytes then
// leaves as n output requests (table read, buffer read, then an output load
// that waits while the output is held); the table build after reset or a write to
// block size, seed or direction fills the table, shuffles it with the bit-serial
// 32-step remainder unit and builds the inverse; no input is taken meanwhile
// reset clears control state, restores register defaults and starts a build

module lfsr_seeded_block_interleaver
#(
    parameter int MAX_BLOCK = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    lsbi_in_if.sink                         in_ch,
    lsbi_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [lsbi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsbi_pkg::CFG_DATA_W-1:0] cfg_data
);

    lsbi_pkg::cmd_t  cmd;
    lsbi_pkg::stat_t stat;

    lsbi_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    lsbi_datapath #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_ch.valid),
        .in_data   (in_ch.data_byte),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_data  (out_ch.out_byte),
        .out_last  (out_ch.last),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign in_ch.ready = cmd.load_en;

    // a write to block size, seed or direction starts a rebuild, so no byte is taken next cycle
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        stat.cfg_hit |=> !in_ch.ready)
        else $error("input taken straight after a register write");

    // a waiting output request keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=>
            out_ch.valid && $stable(out_ch.out_byte) && $stable(out_ch.last))
        else $error("output request changed while waiting");

    // no output is loaded while bytes are being taken
    a_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !cmd.out_load)
        else $error("output loaded during block load");

endmodule

### test/lfsr_seeded_block_interleaver_tb.sv
`timescale 1ns / 1ps

module lfsr_seeded_block_interleaver_tb;

    localparam int MAX_BLOCK = 64;
    localparam logic [lsbi_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [lsbi_pkg::DATA_W-1:0] out_byte;
        logic                        last;
    } perm_byte_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lsbi_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lsbi_pkg::CFG_DATA_W-1:0] cfg_data;

    lsbi_in_if in_ch ();
    lsbi_out_if out_ch ();

    lfsr_seeded_block_interleaver #(.MAX_BLOCK(MAX_BLOCK)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow copy of the block state
    logic [lsbi_pkg::BS_W-1:0]   size_reg;
    logic [lsbi_pkg::SEED_W-1:0] seed_reg;
    logic                        dir_reg;
    logic [5:0]                  fwd_perm [MAX_BLOCK];
    logic [5:0]                  inv_perm [MAX_BLOCK];
    logic [lsbi_pkg::DATA_W-1:0] blk_buf [MAX_BLOCK];
    int                          fill;

    perm_byte_t pending_bytes[$];
    int  mismatches;
    int  build_wait;
    bit  quiet;
    bit  hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int active_size();
        int n;
        n = size_reg;
        if (n == 0)
            n = 1;
        if (n > MAX_BLOCK)
            n = MAX_BLOCK;
        return n;
    endfunction

    // fisher-yates shuffle driven by the galois lfsr
    function automatic void rebuild_perm();
        int n;
        logic [31:0] r;
        logic [31:0] j;
        logic [5:0] t;
        n = active_size();
        for (int i = 0; i < MAX_BLOCK; i++)
        begin
            fwd_perm[i] = (i < n) ? i[5:0] : 6'd0;
            inv_perm[i] = 6'd0;
        end
        r = seed_reg;
        for (int i = n - 1; i > 0; i--)
        begin
            r = r[0] ? ((r >> 1) ^ lsbi_pkg::LFSR_TAPS) : (r >> 1);
            j = r % (i + 1);
            t = fwd_perm[i];
            fwd_perm[i] = fwd_perm[j];
            fwd_perm[j] = t;
        end
        for (int i = 0; i < n; i++)
            inv_perm[fwd_perm[i]] = i[5:0];
        fill = 0;
        build_wait = n + (n - 1) * 37 + 2 * n + 8;
    endfunction

    // load one byte and queue the permuted block once it is full
    function automatic void predict_byte(logic [lsbi_pkg::DATA_W-1:0] b);
        int n;
        perm_byte_t e;
        n = active_size();
        if (fill >= n)
            fill = 0;
        blk_buf[fill] = b;
        fill++;
        if (fill == n)
        begin
            for (int i = 0; i < n; i++)
            begin
                e.out_byte = blk_buf[dir_reg ? inv_perm[i] : fwd_perm[i]];
                e.last = (i == n - 1);
                pending_bytes.push_back(e);
            end
            fill = 0;
        end
    endfunction

    function automatic int pick_gap();
        if (quiet)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one request, caller stands at a rising edge
    task automatic send_byte(input logic [lsbi_pkg::DATA_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_byte(b);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // stop sending and wait for every expected byte
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // register write, only once any table build has finished
    task automatic write_reg(input logic [lsbi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        repeat (build_wait) @(posedge clk);
        build_wait = 0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            lsbi_pkg::REG_BLOCK_SIZE: size_reg = value[lsbi_pkg::BS_W-1:0];
            lsbi_pkg::REG_SEED:       seed_reg = value;
            lsbi_pkg::REG_DIRECTION:  dir_reg = value[0];
            default:                  ;
        endcase
        if (idx != REG_UNUSED)
            rebuild_perm();
    endtask

    task automatic set_config(input logic [6:0] sz, input logic [31:0] sd, input logic dr);
        write_reg(lsbi_pkg::REG_BLOCK_SIZE, {25'd0, sz});
        write_reg(lsbi_pkg::REG_SEED, sd);
        write_reg(lsbi_pkg::REG_DIRECTION, {31'd0, dr});
    endtask

    // size one: every byte leaves at once marked last
    task automatic test_size_one();
        set_config(7'd1, 32'h1234_5678, 1'b0);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'haa);
        send_byte(8'h55);
        drain();
    endtask

    // size zero behaves as size one
    task automatic test_size_zero();
        write_reg(lsbi_pkg::REG_BLOCK_SIZE, 32'd0);
        send_byte(8'h81);
        send_byte(8'h7e);
        drain();
    endtask

    // a register write throws away a half loaded block
    task automatic test_partial_discard();
        set_config(7'd4, 32'h0000_0000, 1'b0);
        send_byte(8'h11);
        send_byte(8'h22);
        drain();
        write_reg(lsbi_pkg::REG_SEED, 32'hdead_beef);
        send_random(4);
        drain();
    endtask

    // unknown index leaves the block and its load untouched
    task automatic test_unknown_index();
        send_byte(8'h01);
        send_byte(8'h80);
        drain();
        write_reg(REG_UNUSED, 32'hffff_ffff);
        send_byte(8'hfe);
        send_byte(8'h7f);
        drain();
    endtask

    // deinterleave and junk in the upper data bits
    task automatic test_deinterleave();
        set_config(7'd2, 32'hffff_ffff, 1'b1);
        send_random(4);
        drain();
        write_reg(lsbi_pkg::REG_BLOCK_SIZE, 32'hffff_ff83);
        write_reg(lsbi_pkg::REG_DIRECTION, 32'hffff_fffe);
        send_random(3);
        drain();
    endtask

    // receiver holds off long enough for the input to stall
    task automatic test_backpressure();
        set_config(7'd8, $urandom, 1'b0);
        quiet = 1'b1;
        hold_req = 1'b1;
        send_random(16);
        quiet = 1'b0;
        drain();
    endtask

    // random settings, the largest size once
    task automatic test_random_blocks();
        int n;
        set_config(7'd127, 32'hffff_ffff, 1'b1);
        quiet = 1'b1;
        send_random(64);
        quiet = 1'b0;
        drain();
        for (int p = 0; p < 3; p++)
        begin
            n = $urandom_range(2, 8);
            set_config(n[6:0], $urandom, 1'($urandom_range(0, 1)));
            quiet = (p == 1);
            send_random(n * $urandom_range(1, 2) + $urandom_range(0, 1));
            quiet = 1'b0;
            drain();
        end
    endtask

    // receiver ready with random gaps and an occasional long hold
    initial
    begin
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                out_ch.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    // compare each output request against the oldest expectation
    always @(posedge clk)
    begin
        perm_byte_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected output byte %h last %b", $time,
                         out_ch.out_byte, out_ch.last);
                mismatches++;
            end
            else
            begin
                e = pending_bytes.pop_front();
                if (out_ch.out_byte !== e.out_byte)
                begin
                    $display("%0t: out_byte expected %h actual %h", $time,
                             e.out_byte, out_ch.out_byte);
                    mismatches++;
                end
                if (out_ch.last !== e.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, e.last, out_ch.last);
                    mismatches++;
                end
            end
        end
    end

    // overall time limit
    initial
    begin
        #4000000;
        $display("lfsr_seeded_block_interleaver test failed");
        $finish;
    end

    initial
    begin
        mismatches = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= lsbi_pkg::REG_BLOCK_SIZE;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= '0;
        size_reg = lsbi_pkg::BS_RESET;
        seed_reg = lsbi_pkg::SEED_RESET;
        dir_reg = 1'b0;
        rebuild_perm();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_size_one();
        test_size_zero();
        test_partial_discard();
        test_unknown_index();
        test_deinterleave();
        test_backpressure();
        test_random_blocks();

        if (pending_bytes.size() != 0)
        begin
            $display("%0t: %0d expected bytes never came", $time, pending_bytes.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("lfsr_seeded_block_interleaver test passed");
        else
            $display("lfsr_seeded_block_interleaver test failed");
        $finish;
    end

endmodule
